@@ hdl/wmaf_pkg.sv @@
// Shared constants, types and helpers of the weighted moving average filter.
`timescale 1ns / 1ps
package wmaf_pkg;

  localparam int WINDOW   = 100;
  localparam int CHANNELS = 10;

  localparam int CH_W     = 4;
  localparam int SMP_W    = 12;
  localparam int SMP_MAX  = (1 << SMP_W) - 1;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W   = $clog2(WINDOW);

  localparam int HIST_DEPTH = CHANNELS * WINDOW;
  localparam int HA_W       = $clog2(HIST_DEPTH);

  localparam longint WEIGHT_SUM = longint'(WINDOW) * longint'(WINDOW + 1) / 2;
  localparam int     PS_W       = $clog2(longint'(SMP_MAX) * longint'(WINDOW) + 1);
  localparam int     WS_W       = $clog2(longint'(SMP_MAX) * WEIGHT_SUM + 1);

  // Reciprocal of the total weight scaled by 2**WS_W; the quotient estimate
  // it gives is low by at most one.
  localparam int              RCP_W = WS_W - $clog2(WEIGHT_SUM) + 1;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((longint'(1) << WS_W) / WEIGHT_SUM);

  localparam int CST_W      = WS_W + PS_W;
  localparam int OUTQ_DEPTH = 8;
  localparam int OQ_AW      = $clog2(OUTQ_DEPTH);
  localparam int CREDIT_W   = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic [WS_W-1:0] wsum;
    logic [PS_W-1:0] psum;
  } chan_state_t;

  typedef struct packed {
    logic            valid;
    logic            oob;
    logic [CH_W-1:0] ch;
    logic [WS_W-1:0] wsum;
  } upd_item_t;

  typedef struct packed {
    logic             valid;
    logic [CH_W-1:0]  ch;
    logic [SMP_W-1:0] filtered;
  } res_item_t;

  function automatic logic chan_in_range(input logic [CH_W-1:0] ch);
    return {1'b0, ch} < (CH_W + 1)'(CHANNELS);
  endfunction

endpackage

@@ hdl/wmaf_in_if.sv @@
// Request channel carrying one sample and its channel number.
`timescale 1ns / 1ps
interface wmaf_in_if;
  logic                        valid;
  logic                        ready;
  logic [wmaf_pkg::CH_W-1:0]   channel;
  logic [wmaf_pkg::SMP_W-1:0]  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

@@ hdl/wmaf_out_if.sv @@
// Result channel carrying one filtered value and its channel number.
`timescale 1ns / 1ps
interface wmaf_out_if;
  logic                        valid;
  logic                        ready;
  logic [wmaf_pkg::CH_W-1:0]   channel_out;
  logic [wmaf_pkg::SMP_W-1:0]  filtered;

  modport source (output valid, output channel_out, output filtered, input ready);
  modport sink (input valid, input channel_out, input filtered, output ready);
endinterface

@@ hdl/wmaf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module wmaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/wmaf_update.sv @@
// History and running-sum memories with the per-request read-modify-write.
`timescale 1ns / 1ps
module wmaf_update (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc_i,
  input  logic [wmaf_pkg::CH_W-1:0]  ch_i,
  input  logic [wmaf_pkg::SMP_W-1:0] sample_i,
  output wmaf_pkg::upd_item_t        item_o,
  output logic                       clearing_o
);

  logic                           clearing_r;
  logic [wmaf_pkg::HA_W-1:0]      clr_cnt_r;
  logic [wmaf_pkg::SLOT_W-1:0]    slot_r [wmaf_pkg::CHANNELS];

  logic                           in_ok;
  logic [wmaf_pkg::CH_IDX_W-1:0]  ch_idx;
  logic [wmaf_pkg::SLOT_W-1:0]    slot_cur;
  logic [wmaf_pkg::HA_W-1:0]      hist_raddr;

  logic                           s1_valid_r;
  logic                           s1_oob_r;
  logic [wmaf_pkg::CH_W-1:0]      s1_ch_r;
  logic [wmaf_pkg::CH_IDX_W-1:0]  s1_idx_r;
  logic [wmaf_pkg::SMP_W-1:0]     s1_x_r;
  logic [wmaf_pkg::HA_W-1:0]      s1_pos_r;

  logic                           wb_valid_r;
  logic [wmaf_pkg::CH_IDX_W-1:0]  wb_idx_r;
  wmaf_pkg::chan_state_t          wb_state_r;
  wmaf_pkg::upd_item_t            item_r;

  wmaf_pkg::chan_state_t          cst_rdata;
  wmaf_pkg::chan_state_t          cst_cur;
  wmaf_pkg::chan_state_t          cst_new;
  wmaf_pkg::chan_state_t          cst_wdata;
  logic [wmaf_pkg::SMP_W-1:0]     hist_rdata;
  logic                           upd_we;
  logic                           hist_we;
  logic [wmaf_pkg::HA_W-1:0]      hist_waddr;
  logic [wmaf_pkg::SMP_W-1:0]     hist_wdata;
  logic                           cst_we;
  logic [wmaf_pkg::CH_IDX_W-1:0]  cst_waddr;

  always_comb begin
    in_ok      = acc_i && wmaf_pkg::chan_in_range(ch_i);
    ch_idx     = wmaf_pkg::chan_in_range(ch_i) ? ch_i[wmaf_pkg::CH_IDX_W-1:0] : '0;
    slot_cur   = slot_r[ch_idx];
    hist_raddr = wmaf_pkg::HA_W'(ch_idx) * wmaf_pkg::HA_W'(wmaf_pkg::WINDOW)
               + wmaf_pkg::HA_W'(slot_cur);
  end

  // The write of the previous request lands at the same edge as this request's
  // read, so a request that follows one of the same channel takes the sums
  // from the write-back register.
  always_comb begin
    cst_cur = (wb_valid_r && (wb_idx_r == s1_idx_r)) ? wb_state_r : cst_rdata;
    cst_new.wsum = cst_cur.wsum - wmaf_pkg::WS_W'(cst_cur.psum)
                 + wmaf_pkg::WS_W'(s1_x_r) * wmaf_pkg::WS_W'(wmaf_pkg::WINDOW);
    cst_new.psum = cst_cur.psum - wmaf_pkg::PS_W'(hist_rdata)
                 + wmaf_pkg::PS_W'(s1_x_r);
    upd_we = s1_valid_r && !s1_oob_r;
  end

  always_comb begin
    hist_we    = clearing_r || upd_we;
    hist_waddr = clearing_r ? clr_cnt_r : s1_pos_r;
    hist_wdata = clearing_r ? '0 : s1_x_r;
    cst_we     = (clearing_r && (clr_cnt_r < wmaf_pkg::HA_W'(wmaf_pkg::CHANNELS))) || upd_we;
    cst_waddr  = clearing_r ? clr_cnt_r[wmaf_pkg::CH_IDX_W-1:0] : s1_idx_r;
    cst_wdata  = clearing_r ? '0 : cst_new;
  end

  wmaf_ram #(
    .WIDTH (wmaf_pkg::SMP_W),
    .DEPTH (wmaf_pkg::HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  wmaf_ram #(
    .WIDTH (wmaf_pkg::CST_W),
    .DEPTH (wmaf_pkg::CHANNELS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (cst_we),
    .waddr (cst_waddr),
    .wdata (cst_wdata),
    .raddr (ch_idx),
    .rdata (cst_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r   <= 1'b1;
      clr_cnt_r    <= '0;
      s1_valid_r   <= 1'b0;
      wb_valid_r   <= 1'b0;
      item_r.valid <= 1'b0;
      for (int i = 0; i < wmaf_pkg::CHANNELS; i++) begin
        slot_r[i] <= '0;
      end
    end else begin
      if (clearing_r) begin
        if (clr_cnt_r == wmaf_pkg::HA_W'(wmaf_pkg::HIST_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end else begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
        end
      end
      if (in_ok) begin
        slot_r[ch_idx] <= (slot_cur == wmaf_pkg::SLOT_W'(wmaf_pkg::WINDOW - 1)) ?
                          '0 : slot_cur + 1'b1;
      end
      s1_valid_r   <= acc_i;
      wb_valid_r   <= upd_we;
      item_r.valid <= s1_valid_r;
    end
    s1_oob_r    <= !wmaf_pkg::chan_in_range(ch_i);
    s1_ch_r     <= ch_i;
    s1_idx_r    <= ch_idx;
    s1_x_r      <= sample_i;
    s1_pos_r    <= hist_raddr;
    wb_idx_r    <= s1_idx_r;
    wb_state_r  <= cst_new;
    item_r.oob  <= s1_oob_r;
    item_r.ch   <= s1_ch_r;
    item_r.wsum <= cst_new.wsum;
  end

  assign item_o     = item_r;
  assign clearing_o = clearing_r;

endmodule

@@ hdl/wmaf_divide.sv @@
// Division of the weighted sum by the total weight via reciprocal and correction.
`timescale 1ns / 1ps
module wmaf_divide (
  input  logic                clk,
  input  logic                rst_n,
  input  wmaf_pkg::upd_item_t item_i,
  output wmaf_pkg::res_item_t res_o
);

  localparam int P1_W = wmaf_pkg::WS_W + wmaf_pkg::RCP_W;

  logic [P1_W-1:0]            prod1;
  logic                       s2_valid_r;
  logic                       s2_oob_r;
  logic [wmaf_pkg::CH_W-1:0]  s2_ch_r;
  logic [wmaf_pkg::WS_W-1:0]  s2_ws_r;
  logic [wmaf_pkg::SMP_W-1:0] s2_q_r;

  logic                       s3_valid_r;
  logic                       s3_oob_r;
  logic [wmaf_pkg::CH_W-1:0]  s3_ch_r;
  logic [wmaf_pkg::WS_W-1:0]  s3_ws_r;
  logic [wmaf_pkg::SMP_W-1:0] s3_q_r;
  logic [wmaf_pkg::WS_W-1:0]  s3_prod_r;

  logic [wmaf_pkg::WS_W-1:0]  rem;
  logic [wmaf_pkg::SMP_W-1:0] q_fin;
  wmaf_pkg::res_item_t        res_r;

  assign prod1 = P1_W'(item_i.wsum) * P1_W'(wmaf_pkg::RECIP);

  // The estimate is the true quotient or one less; the remainder decides.
  always_comb begin
    rem   = s3_ws_r - s3_prod_r;
    q_fin = (rem >= wmaf_pkg::WS_W'(wmaf_pkg::WEIGHT_SUM)) ? s3_q_r + 1'b1 : s3_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      s2_valid_r  <= item_i.valid;
      s3_valid_r  <= s2_valid_r;
      res_r.valid <= s3_valid_r;
    end
    s2_oob_r  <= item_i.oob;
    s2_ch_r   <= item_i.ch;
    s2_ws_r   <= item_i.wsum;
    s2_q_r    <= prod1[wmaf_pkg::WS_W +: wmaf_pkg::SMP_W];
    s3_oob_r  <= s2_oob_r;
    s3_ch_r   <= s2_ch_r;
    s3_ws_r   <= s2_ws_r;
    s3_q_r    <= s2_q_r;
    s3_prod_r <= wmaf_pkg::WS_W'(s2_q_r) * wmaf_pkg::WS_W'(wmaf_pkg::WEIGHT_SUM);
    res_r.ch       <= s3_ch_r;
    res_r.filtered <= s3_oob_r ? '0 : q_fin;
  end

  assign res_o = res_r;

endmodule

@@ hdl/wmaf_outq.sv @@
// Output queue that holds finished results until the sink takes them.
`timescale 1ns / 1ps
module wmaf_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  wmaf_pkg::res_item_t res_i,
  wmaf_out_if.source          out_chan
);

  logic [wmaf_pkg::CH_W-1:0]     q_ch_r   [wmaf_pkg::OUTQ_DEPTH];
  logic [wmaf_pkg::SMP_W-1:0]    q_val_r  [wmaf_pkg::OUTQ_DEPTH];
  logic [wmaf_pkg::OQ_AW-1:0]    wr_ptr_r;
  logic [wmaf_pkg::OQ_AW-1:0]    rd_ptr_r;
  logic [wmaf_pkg::CREDIT_W-1:0] cnt_r;
  logic                          pop;

  assign pop               = out_chan.valid && out_chan.ready;
  assign out_chan.valid       = (cnt_r != '0);
  assign out_chan.channel_out = q_ch_r[rd_ptr_r];
  assign out_chan.filtered    = q_val_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (res_i.valid) begin
        wr_ptr_r <= (wr_ptr_r == wmaf_pkg::OQ_AW'(wmaf_pkg::OUTQ_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == wmaf_pkg::OQ_AW'(wmaf_pkg::OUTQ_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (res_i.valid && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!res_i.valid && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (res_i.valid) begin
      q_ch_r[wr_ptr_r]  <= res_i.ch;
      q_val_r[wr_ptr_r] <= res_i.filtered;
    end
  end

endmodule

@@ hdl/weighted_moving_average_filter.sv @@
// Top level of the multi-channel linearly weighted moving average filter.
//
//   Port      Role    Payload
//   in_chan   sink    channel (4 b), sample (12 b)
//   out_chan  source  channel_out (4 b), filtered (12 b)
//
// One request is accepted per cycle while ready is high; the accepting edge
// also starts the RAM read, and the result then passes the sum update, three
// divider stages and the write into the output queue before it is offered.
// An output queue of eight entries with a credit count keeps the pipeline
// free of stalls; ready drops when eight results are owed and during clearing.
// After reset a clearing pass over all CHANNELS*WINDOW (1000) history entries
// zeroes the history and sum memories, and no request is accepted during it.
`timescale 1ns / 1ps
module weighted_moving_average_filter (
  input  logic       clk,
  input  logic       rst_n,
  wmaf_in_if.sink    in_chan,
  wmaf_out_if.source out_chan
);

  logic                          clearing;
  logic                          acc_in;
  logic                          acc_out;
  logic [wmaf_pkg::CREDIT_W-1:0] credit_r;
  logic [wmaf_pkg::CREDIT_W-1:0] credit_nxt;
  wmaf_pkg::upd_item_t           upd_item;
  wmaf_pkg::res_item_t           res_item;

  assign in_chan.ready = !clearing
                       && (credit_r < wmaf_pkg::CREDIT_W'(wmaf_pkg::OUTQ_DEPTH));
  assign acc_in        = in_chan.valid && in_chan.ready;
  assign acc_out       = out_chan.valid && out_chan.ready;

  always_comb begin
    credit_nxt = credit_r;
    if (acc_in && !acc_out) begin
      credit_nxt = credit_r + 1'b1;
    end else if (!acc_in && acc_out) begin
      credit_nxt = credit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  wmaf_update u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_i      (acc_in),
    .ch_i       (in_chan.channel),
    .sample_i   (in_chan.sample),
    .item_o     (upd_item),
    .clearing_o (clearing)
  );

  wmaf_divide u_divide (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_i (upd_item),
    .res_o  (res_item)
  );

  wmaf_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_i    (res_item),
    .out_chan (out_chan)
  );

`ifndef NO_ASSERTIONS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= wmaf_pkg::CREDIT_W'(wmaf_pkg::OUTQ_DEPTH))
    else $error("outstanding result count exceeds queue depth");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_chan.ready)
    else $error("request accepted during memory clearing pass");

  a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (credit_r != '0))
    else $error("result offered with no request outstanding");

  a_pipe_owed: assert property (@(posedge clk) disable iff (!rst_n)
    res_item.valid |-> (credit_r != '0))
    else $error("divider produced a result with no request outstanding");
`endif

endmodule

@@ tb/sv/tb_weighted_moving_average_filter.sv @@
// Self-checking testbench for the multi-channel weighted moving average filter.
`timescale 1ns / 1ps
module tb_weighted_moving_average_filter;

  localparam int CLK_PERIOD       = 10;
  localparam int SETTLE_CYCLES    = 12;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int DRAIN_LIMIT      = 5000;
  localparam int MAX_REPORTS      = 40;
  localparam int CH_MAX           = (1 << wmaf_pkg::CH_W) - 1;

  typedef struct {
    logic [wmaf_pkg::CH_W-1:0]  ch;
    logic [wmaf_pkg::SMP_W-1:0] filtered;
  } avg_result_t;

  logic clk;
  logic rst_n;

  wmaf_in_if  in_chan ();
  wmaf_out_if out_chan ();

  weighted_moving_average_filter uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Per-channel copy of the filter state.
  logic [wmaf_pkg::SMP_W-1:0] chan_history [wmaf_pkg::CHANNELS][wmaf_pkg::WINDOW];
  int                         chan_slot [wmaf_pkg::CHANNELS];
  longint                     chan_plain_sum [wmaf_pkg::CHANNELS];
  longint                     chan_weighted_sum [wmaf_pkg::CHANNELS];

  avg_result_t owed_results [$];
  int          error_count;
  bit          src_idle_en;
  bit          sink_idle_en;
  bit          long_hold_req;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic avg_result_t predict_average(input logic [wmaf_pkg::CH_W-1:0] ch,
                                                  input logic [wmaf_pkg::SMP_W-1:0] smp);
    avg_result_t                res;
    logic [wmaf_pkg::SMP_W-1:0] oldest;
    int                         c;
    res.ch       = ch;
    res.filtered = '0;
    if (ch >= wmaf_pkg::CHANNELS) return res;
    c      = ch;
    oldest = chan_history[c][chan_slot[c]];
    // Every older sample loses one unit of weight; the new one enters at WINDOW.
    chan_weighted_sum[c] = chan_weighted_sum[c] - chan_plain_sum[c]
                           + longint'(wmaf_pkg::WINDOW) * longint'(smp);
    chan_plain_sum[c]    = chan_plain_sum[c] - longint'(oldest) + longint'(smp);
    chan_history[c][chan_slot[c]] = smp;
    chan_slot[c] = (chan_slot[c] + 1) % wmaf_pkg::WINDOW;
    res.filtered = wmaf_pkg::SMP_W'(chan_weighted_sum[c] / wmaf_pkg::WEIGHT_SUM);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function automatic logic [wmaf_pkg::SMP_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return wmaf_pkg::SMP_W'(wmaf_pkg::SMP_MAX);
      default: return wmaf_pkg::SMP_W'($urandom_range(0, wmaf_pkg::SMP_MAX));
    endcase
  endfunction

  // Mostly live channels; now and then a channel number past the last one.
  function automatic logic [wmaf_pkg::CH_W-1:0] random_channel();
    if ($urandom_range(0, 9) == 0)
      return wmaf_pkg::CH_W'($urandom_range(wmaf_pkg::CHANNELS, CH_MAX));
    return wmaf_pkg::CH_W'($urandom_range(0, wmaf_pkg::CHANNELS - 1));
  endfunction

  // Valid is left high after a request is taken so that back-to-back
  // requests need no second assignment in the same step.
  task automatic send_sample(input logic [wmaf_pkg::CH_W-1:0] ch,
                             input logic [wmaf_pkg::SMP_W-1:0] smp);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.channel <= ch;
    in_chan.sample  <= smp;
    do @(posedge clk); while (!in_chan.ready);
    owed_results.push_back(predict_average(ch, smp));
  endtask

  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result consumer: random stalls, plus one long hold on request.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    avg_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result ch=%0d filtered=%0d",
                                  out_chan.channel_out, out_chan.filtered));
      end else begin
        want = owed_results.pop_front();
        if (out_chan.channel_out !== want.ch)
          report_mismatch($sformatf("channel_out got %0d, want %0d",
                                    out_chan.channel_out, want.ch));
        if (out_chan.filtered !== want.filtered)
          report_mismatch($sformatf("filtered on ch %0d got %0d, want %0d",
                                    want.ch, out_chan.filtered, want.filtered));
      end
    end
  end

  task automatic test_directed_cases();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    // First samples on cleared channels exercise the start-up ramp.
    send_sample(wmaf_pkg::CH_W'(0), wmaf_pkg::SMP_W'(wmaf_pkg::SMP_MAX));
    send_sample(wmaf_pkg::CH_W'(0), '0);
    send_sample(wmaf_pkg::CH_W'(0), wmaf_pkg::SMP_W'(wmaf_pkg::SMP_MAX));
    send_sample(wmaf_pkg::CH_W'(wmaf_pkg::CHANNELS - 1),
                wmaf_pkg::SMP_W'(wmaf_pkg::SMP_MAX));
    send_sample(wmaf_pkg::CH_W'(wmaf_pkg::CHANNELS - 1), 12'h001);
    send_sample(wmaf_pkg::CH_W'(1), 12'hAAA);
    send_sample(wmaf_pkg::CH_W'(2), 12'h555);
    send_sample(wmaf_pkg::CH_W'(3), 12'h800);
    send_sample(wmaf_pkg::CH_W'(5), 12'h7FF);
    // Channels past the last one must answer zero and leave all state alone.
    for (int ch = wmaf_pkg::CHANNELS; ch <= CH_MAX; ch++)
      send_sample(wmaf_pkg::CH_W'(ch),
                  (ch % 2) ? 12'h555 : wmaf_pkg::SMP_W'(wmaf_pkg::SMP_MAX));
    send_sample(wmaf_pkg::CH_W'(0), 12'h001);
    send_sample(wmaf_pkg::CH_W'(wmaf_pkg::CHANNELS - 1), '0);
  endtask

  // Fill one channel's whole window with full scale, then flush it with zeros.
  task automatic test_full_scale_window();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (wmaf_pkg::WINDOW + 5)
      send_sample(wmaf_pkg::CH_W'(4), wmaf_pkg::SMP_W'(wmaf_pkg::SMP_MAX));
    repeat (wmaf_pkg::WINDOW + 5) send_sample(wmaf_pkg::CH_W'(4), '0);
  endtask

  // The consumer holds off long enough for the output queue to fill and the
  // input to stall while requests keep coming.
  task automatic test_output_backpressure();
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    long_hold_req = 1'b1;
    repeat (40) send_sample(random_channel(), random_sample());
  endtask

  task automatic test_random_traffic(input int count, input bit with_idle);
    src_idle_en  = with_idle;
    sink_idle_en = with_idle;
    repeat (count) send_sample(random_channel(), random_sample());
  endtask

  initial begin : run_tests
    int waited;
    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.channel <= '0;
    in_chan.sample  <= '0;
    error_count   = 0;
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    long_hold_req = 1'b0;
    foreach (chan_history[c, s]) chan_history[c][s] = '0;
    foreach (chan_slot[c]) begin
      chan_slot[c]         = 0;
      chan_plain_sum[c]    = 0;
      chan_weighted_sum[c] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    wait_for_results();
    test_full_scale_window();
    wait_for_results();
    test_output_backpressure();
    wait_for_results();
    test_random_traffic(1300, 1'b1);
    wait_for_results();
    test_random_traffic(300, 1'b0);

    in_chan.valid <= 1'b0;
    waited = 0;
    while (owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
